// File: hw/rtl/sdiv_pkg.sv
// ----------------------------------------------------------------------------
// Signed divider package
// Widths, field layout and the stage record shared by the divider pipeline.
// ----------------------------------------------------------------------------
package sdiv_pkg;

  // Operand width
  localparam int unsigned Width = 32;

  // Stream word widths: two operands in, quotient/remainder/flag out
  localparam int unsigned InW  = ((2 * Width + 7) / 8) * 8;
  localparam int unsigned OutW = ((2 * Width + 1 + 7) / 8) * 8;

  // Bit position of the divide-by-zero flag in the result word
  localparam int unsigned DzBit = 2 * Width;

  typedef logic [Width-1:0] word_t;

  // Payload carried from one division step to the next
  typedef struct packed {
    word_t rem;   // partial remainder
    word_t qa;    // dividend bits still to use (top), quotient bits (bottom)
    word_t mb;    // divisor magnitude
    logic  sa;    // dividend sign
    logic  sq;    // quotient sign
    logic  dz;    // divisor was zero
  } stage_t;

endpackage

// File: hw/rtl/signed_integer_divider_top.sv
// Stages: 1 magnitude stage, 32 division steps of one quotient bit each,
// 1 sign-fix stage, each followed by its pipeline register.
// Throughput: one transaction per cycle unless the skid register is full;
// each division step is a single 33-bit subtract. An output skid register
// takes up one stalled result. Reset clears all valid bits, not payload.
// ----------------------------------------------------------------------------
// Signed integer divider
// Pipelined restoring division of signed operands, truncated quotient,
// remainder with the dividend's sign, divide-by-zero flag.
// ----------------------------------------------------------------------------
module signed_integer_divider_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [31:0] dividend, [63:32] divisor
  input  logic [sdiv_pkg::InW-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [31:0] quotient, [63:32] remainder, [64] divide_by_zero, [71:65] zero
  output logic [sdiv_pkg::OutW-1:0] m_axis_tdata
);
  import sdiv_pkg::*;

  word_t  dividend;
  word_t  divisor;
  logic   en;
  stage_t init_d;
  stage_t init_q;
  logic   init_v_q;

  logic   step_v [Width+1];
  stage_t step_s [Width+1];

  word_t             q_mag;
  logic [OutW-1:0]   out_d;
  logic [OutW-1:0]   out_q;
  logic              out_v_q;
  logic [OutW-1:0]   skid_q;
  logic              skid_v_q;

  // Pipeline advances while the skid register is empty
  assign en            = ~skid_v_q;
  assign s_axis_tready = en;

  assign dividend = s_axis_tdata[Width-1:0];
  assign divisor  = s_axis_tdata[2*Width-1:Width];

  // Magnitudes and signs; a zero divisor runs through and leaves the
  // dividend magnitude as remainder
  always_comb begin
    init_d.sa  = dividend[Width-1];
    init_d.sq  = dividend[Width-1] ^ divisor[Width-1];
    init_d.dz  = (divisor == '0);
    init_d.rem = '0;
    init_d.qa  = dividend[Width-1] ? (~dividend + word_t'(1)) : dividend;
    init_d.mb  = divisor[Width-1] ? (~divisor + word_t'(1)) : divisor;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_v_q <= 1'b0;
    end else if (en) begin
      init_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      init_q <= init_d;
    end
  end

  assign step_v[0] = init_v_q;
  assign step_s[0] = init_q;

  // Division steps, most significant quotient bit first
  for (genvar i = 0; i < Width; i++) begin : g_step
    sdiv_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (step_v[i]),
      .stage_i (step_s[i]),
      .valid_o (step_v[i+1]),
      .stage_o (step_s[i+1])
    );
  end

  // Sign fix and result packing
  always_comb begin
    q_mag = step_s[Width].qa;
    out_d = '0;
    out_d[Width-1:0] = step_s[Width].dz ? '0 :
                       (step_s[Width].sq ? (~q_mag + word_t'(1)) : q_mag);
    out_d[2*Width-1:Width] = step_s[Width].sa ?
                             (~step_s[Width].rem + word_t'(1)) : step_s[Width].rem;
    out_d[DzBit] = step_s[Width].dz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= step_v[Width];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // Skid register: holds the result that was not taken when the pipe moved
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) begin
        skid_v_q <= 1'b0;
      end
    end else if (out_v_q && !m_axis_tready) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) begin
      skid_q <= out_q;
    end
  end

  assign m_axis_tvalid = skid_v_q | out_v_q;
  assign m_axis_tdata  = skid_v_q ? skid_q : out_q;

  // Checks
  a_dz_quot_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[DzBit] |-> m_axis_tdata[Width-1:0] == '0)
    else $error("divide by zero result with nonzero quotient");

  a_skid_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> !s_axis_tready)
    else $error("skid register full while pipeline runs");

  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !skid_v_q && out_v_q && !m_axis_tready |=> skid_v_q && skid_q == $past(out_q))
    else $error("stalled result not captured in skid register");

endmodule

// File: hw/rtl/sdiv_step.sv
// ----------------------------------------------------------------------------
// Divider step stage
// One restoring division step (one quotient bit) and its pipeline register.
// ----------------------------------------------------------------------------
module sdiv_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  sdiv_pkg::stage_t stage_i,
  output logic            valid_o,
  output sdiv_pkg::stage_t stage_o
);
  import sdiv_pkg::*;

  logic          carry;
  word_t         shifted;
  logic [Width:0] diff;
  logic          take;
  stage_t        stage_d;
  stage_t        stage_q;
  logic          valid_q;

  // Shift next dividend bit into the remainder, trial subtract
  always_comb begin
    carry   = stage_i.rem[Width-1];
    shifted = {stage_i.rem[Width-2:0], stage_i.qa[Width-1]};
    diff    = {carry, shifted} - {1'b0, stage_i.mb};
    take    = ~diff[Width];
    stage_d     = stage_i;
    stage_d.rem = take ? diff[Width-1:0] : shifted;
    stage_d.qa  = {stage_i.qa[Width-2:0], take};
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
